// ----- src/tdq_pkg.sv -----
// ----------------------------------------------------------------------------
// tdq_pkg
// types and codes shared by the timer deadline queue cells and controller
// ----------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [1:0] K_ADD    = 2'd0;
  localparam logic [1:0] K_CANCEL = 2'd1;
  localparam logic [1:0] K_TICK   = 2'd2;
  // unused kind, ignored by the block
  localparam logic [1:0] K_NOP    = 2'd3;

  localparam logic [2:0] RK_ADDED    = 3'd0;
  localparam logic [2:0] RK_CANCELED = 3'd1;
  localparam logic [2:0] RK_MISS     = 3'd2;
  localparam logic [2:0] RK_FULL     = 3'd3;
  localparam logic [2:0] RK_EXPIRED  = 3'd4;
  localparam logic [2:0] RK_DONE     = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ADD,
    CMD_FREE,
    CMD_MARK,
    CMD_REARM
  } cmd_op_t;

  typedef enum logic {
    SCAN_ALL,
    SCAN_DUE
  } scan_mode_t;

  typedef struct packed {
    cmd_op_t    op;
    scan_mode_t mode;
    logic [47:0] now;
    logic [47:0] expire;
    logic [31:0] period;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/tdq_cell.sv -----
// ----------------------------------------------------------------------------
// tdq_cell
// one timer slot and one stage of the earliest-deadline / free-slot chain
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tdq_pkg::cmd_t cmd,
  input  wire logic          sel,
  input  wire logic          in_any,
  input  wire logic [47:0]   in_time,
  input  wire logic [IW-1:0] in_idx,
  input  wire logic          in_free_any,
  input  wire logic [IW-1:0] in_free_idx,
  output logic               out_any,
  output logic [47:0]        out_time,
  output logic [IW-1:0]      out_idx,
  output logic               out_free_any,
  output logic [IW-1:0]      out_free_idx,
  output logic               busy,
  output logic [7:0]         tag
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [47:0] exp_r, exp_nxt;
  logic [31:0] per_r, per_nxt;
  logic [48:0] sum;
  logic        cand;

  logic          any_r;
  logic [47:0]   time_r;
  logic [IW-1:0] idx_r;
  logic          free_any_r;
  logic [IW-1:0] free_idx_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    tag_nxt  = tag_r;
    exp_nxt  = exp_r;
    per_nxt  = per_r;
    sum      = 49'(cmd.now) + 49'(per_r);
    case (cmd.op)
      tdq_pkg::CMD_ADD: begin
        if (sel) begin
          busy_nxt = 1'b1;
          tag_nxt  = tag_r + 8'd1;
          exp_nxt  = cmd.expire;
          per_nxt  = cmd.period;
        end
      end
      tdq_pkg::CMD_FREE: begin
        if (sel) busy_nxt = 1'b0;
      end
      tdq_pkg::CMD_MARK: begin
        if (sel) done_nxt = 1'b1;
      end
      tdq_pkg::CMD_REARM: begin
        if (done_r) begin
          done_nxt = 1'b0;
          if (per_r != 32'd0) begin
            exp_nxt = sum[48] ? {48{1'b1}} : sum[47:0];
          end else begin
            busy_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.mode == tdq_pkg::SCAN_DUE) begin
      cand = busy_r && !done_r && (exp_r <= cmd.now);
    end else begin
      cand = busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      done_r     <= 1'b0;
      tag_r      <= 8'd0;
      any_r      <= 1'b0;
      free_any_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      tag_r  <= tag_nxt;
      if (cand && (!in_any || exp_r < in_time)) begin
        any_r <= 1'b1;
      end else begin
        any_r <= in_any;
      end
      free_any_r <= in_free_any || !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
    per_r <= per_nxt;
    if (cand && (!in_any || exp_r < in_time)) begin
      time_r <= exp_r;
      idx_r  <= IW'(IDX);
    end else begin
      time_r <= in_time;
      idx_r  <= in_idx;
    end
    if (!in_free_any && !busy_r) begin
      free_idx_r <= IW'(IDX);
    end else begin
      free_idx_r <= in_free_idx;
    end
  end

  assign out_any      = any_r;
  assign out_time     = time_r;
  assign out_idx      = idx_r;
  assign out_free_any = free_any_r;
  assign out_free_idx = free_idx_r;
  assign busy         = busy_r;
  assign tag          = tag_r;

endmodule

`default_nettype wire

// ----- src/timer_deadline_queue_unit.sv -----
// ----------------------------------------------------------------------------
// timer_deadline_queue_unit
// slot-based timer store with add, cancel and tick, emitting expired timers
// ----------------------------------------------------------------------------
// One word is handled at a time. Every lookup (earliest deadline, lowest free
// slot, next due timer) runs down the chain of SLOTS cells, one cell a cycle.
// Each timer that a tick expires costs one scan of the chain. Results wait in
// an output register.
`default_nettype none

module timer_deadline_queue_unit #(
  parameter int SLOTS = tdq_pkg::SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // expire_at[47:0], interval[79:48], target_slot[83:80],
  // target_generation[91:84], now[139:92]
  input  wire logic [143:0] in_tdata,
  // kind[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // slot[3:0], generation[11:4], earliest_changed[12], next_deadline[60:13],
  // next_valid[61]
  output logic [63:0]       out_tdata,
  // result_kind[2:0]
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  tdq_pkg::state_t     state_r, state_nxt;
  tdq_pkg::scan_mode_t mode_r, mode_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [47:0] exp_r, exp_nxt;
  logic [31:0] per_r, per_nxt;
  logic [3:0]  tslot_r, tslot_nxt;
  logic [7:0]  tgen_r, tgen_nxt;
  logic [47:0] now_r, now_nxt;
  logic [2:0]  rk_r, rk_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  ok_r, ok_nxt;
  logic [3:0]  oslot_r, oslot_nxt;
  logic [7:0]  ogen_r, ogen_nxt;
  logic        oec_r, oec_nxt;
  logic [47:0] ond_r, ond_nxt;
  logic        onv_r, onv_nxt;
  logic        olast_r, olast_nxt;

  tdq_pkg::cmd_t cmd;
  logic [IW-1:0] sel_idx;
  logic [SLOTS-1:0] cmd_sel;

  logic          lk_any      [SLOTS+1];
  logic [47:0]   lk_time     [SLOTS+1];
  logic [IW-1:0] lk_idx      [SLOTS+1];
  logic          lk_free_any [SLOTS+1];
  logic [IW-1:0] lk_free_idx [SLOTS+1];
  logic          busy_all    [SLOTS];
  logic [7:0]    tag_all     [SLOTS];

  logic [8:0]    tslot_ext;
  logic [IW-1:0] tidx;
  logic          hit;
  logic          changed;
  logic [47:0]   nd;

  assign lk_any[0]      = 1'b0;
  assign lk_time[0]     = 48'd0;
  assign lk_idx[0]      = '0;
  assign lk_free_any[0] = 1'b0;
  assign lk_free_idx[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign cmd_sel[i] = (sel_idx == IW'(i));
    tdq_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .sel          (cmd_sel[i]),
      .in_any       (lk_any[i]),
      .in_time      (lk_time[i]),
      .in_idx       (lk_idx[i]),
      .in_free_any  (lk_free_any[i]),
      .in_free_idx  (lk_free_idx[i]),
      .out_any      (lk_any[i+1]),
      .out_time     (lk_time[i+1]),
      .out_idx      (lk_idx[i+1]),
      .out_free_any (lk_free_any[i+1]),
      .out_free_idx (lk_free_idx[i+1]),
      .busy         (busy_all[i]),
      .tag          (tag_all[i])
    );
  end

  assign tslot_ext = 9'(tslot_r);
  assign tidx      = tslot_ext[IW-1:0];
  assign hit       = (tslot_ext < 9'(SLOTS)) && busy_all[tidx] && (tag_all[tidx] == tgen_r);
  assign changed   = !lk_any[SLOTS] || (exp_r < lk_time[SLOTS]);
  assign nd        = lk_any[SLOTS] ? lk_time[SLOTS] : 48'd0;

  assign in_tready = (state_r == tdq_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    kind_nxt  = kind_r;
    exp_nxt   = exp_r;
    per_nxt   = per_r;
    tslot_nxt = tslot_r;
    tgen_nxt  = tgen_r;
    now_nxt   = now_r;
    rk_nxt    = rk_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    ok_nxt    = ok_r;
    oslot_nxt = oslot_r;
    ogen_nxt  = ogen_r;
    oec_nxt   = oec_r;
    ond_nxt   = ond_r;
    onv_nxt   = onv_r;
    olast_nxt = olast_r;
    sel_idx   = '0;
    cmd.op     = tdq_pkg::CMD_NONE;
    cmd.mode   = mode_r;
    cmd.now    = now_r;
    cmd.expire = exp_r;
    cmd.period = per_r;
    unique case (state_r)
      tdq_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          exp_nxt   = in_tdata[47:0];
          per_nxt   = in_tdata[79:48];
          tslot_nxt = in_tdata[83:80];
          tgen_nxt  = in_tdata[91:84];
          now_nxt   = in_tdata[139:92];
          if (in_tuser == tdq_pkg::K_ADD || in_tuser == tdq_pkg::K_CANCEL ||
              in_tuser == tdq_pkg::K_TICK) begin
            state_nxt = tdq_pkg::ST_EXEC;
          end
        end
      end
      tdq_pkg::ST_EXEC: begin
        cnt_nxt   = '0;
        mode_nxt  = tdq_pkg::SCAN_ALL;
        state_nxt = tdq_pkg::ST_SCAN;
        if (kind_r == tdq_pkg::K_CANCEL) begin
          rk_nxt = hit ? tdq_pkg::RK_CANCELED : tdq_pkg::RK_MISS;
          if (hit) begin
            cmd.op  = tdq_pkg::CMD_FREE;
            sel_idx = tidx;
          end
        end else if (kind_r == tdq_pkg::K_TICK) begin
          mode_nxt = tdq_pkg::SCAN_DUE;
        end
      end
      tdq_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(SLOTS)) begin
          state_nxt = tdq_pkg::ST_OUT;
          ov_nxt    = 1'b1;
          oslot_nxt = 4'd0;
          ogen_nxt  = 8'd0;
          oec_nxt   = 1'b0;
          ond_nxt   = nd;
          onv_nxt   = lk_any[SLOTS];
          olast_nxt = 1'b1;
          if (kind_r == tdq_pkg::K_ADD) begin
            if (!lk_free_any[SLOTS]) begin
              ok_nxt = tdq_pkg::RK_FULL;
            end else begin
              cmd.op    = tdq_pkg::CMD_ADD;
              sel_idx   = lk_free_idx[SLOTS];
              ok_nxt    = tdq_pkg::RK_ADDED;
              oslot_nxt = 4'(lk_free_idx[SLOTS]);
              ogen_nxt  = tag_all[lk_free_idx[SLOTS]] + 8'd1;
              oec_nxt   = changed;
              ond_nxt   = changed ? exp_r : lk_time[SLOTS];
              onv_nxt   = 1'b1;
            end
          end else if (kind_r == tdq_pkg::K_CANCEL) begin
            ok_nxt    = rk_r;
            oslot_nxt = tslot_r;
            ogen_nxt  = tgen_r;
          end else if (mode_r == tdq_pkg::SCAN_DUE) begin
            if (lk_any[SLOTS]) begin
              cmd.op    = tdq_pkg::CMD_MARK;
              sel_idx   = lk_idx[SLOTS];
              ok_nxt    = tdq_pkg::RK_EXPIRED;
              oslot_nxt = 4'(lk_idx[SLOTS]);
              ogen_nxt  = tag_all[lk_idx[SLOTS]];
              ond_nxt   = 48'd0;
              onv_nxt   = 1'b0;
              olast_nxt = 1'b0;
            end else begin
              cmd.op    = tdq_pkg::CMD_REARM;
              mode_nxt  = tdq_pkg::SCAN_ALL;
              cnt_nxt   = '0;
              state_nxt = tdq_pkg::ST_SCAN;
              ov_nxt    = 1'b0;
            end
          end else begin
            ok_nxt = tdq_pkg::RK_DONE;
          end
        end
      end
      tdq_pkg::ST_OUT: begin
        if (out_tready) begin
          ov_nxt = 1'b0;
          if (!olast_r) begin
            mode_nxt  = tdq_pkg::SCAN_DUE;
            cnt_nxt   = '0;
            state_nxt = tdq_pkg::ST_SCAN;
          end else begin
            state_nxt = tdq_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = tdq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdq_pkg::ST_IDLE;
      mode_r  <= tdq_pkg::SCAN_ALL;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    exp_r   <= exp_nxt;
    per_r   <= per_nxt;
    tslot_r <= tslot_nxt;
    tgen_r  <= tgen_nxt;
    now_r   <= now_nxt;
    rk_r    <= rk_nxt;
    ok_r    <= ok_nxt;
    oslot_r <= oslot_nxt;
    ogen_r  <= ogen_nxt;
    oec_r   <= oec_nxt;
    ond_r   <= ond_nxt;
    onv_r   <= onv_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, onv_r, ond_r, oec_r, ogen_r, oslot_r};
  assign out_tuser  = ok_r;
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire

// ----- src/tdq_checker.sv -----
// ----------------------------------------------------------------------------
// tdq_checker
// port-level checks for the timer deadline queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_props (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata,
  input wire logic [2:0]   out_tuser,
  input wire logic         out_tlast
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // one word in flight at a time
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  // expired timers never close the item, everything else does
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser != tdq_pkg::RK_EXPIRED)))
    else $error("tlast does not match result kind");

  // no pending timer means a zero deadline
  a_nd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tdata[61] |-> out_tdata[60:13] == 48'd0)
    else $error("deadline set with no timer pending");

  // an accepted item is never answered in the very next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result too early");

endmodule

bind timer_deadline_queue_unit tdq_props u_tdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ----- test/tdq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_checker
// watches both stream channels of the timer deadline queue, keeps its own
// copy of the timer slots, works out the result words that each accepted
// input word must cause and compares every accepted result word with them
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [143:0] in_tdata,
  input  wire logic [1:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [63:0]  out_tdata,
  input  wire logic [2:0]   out_tuser,
  input  wire logic         out_tlast,
  output int                errors,
  output int                outstanding
);

  localparam int NSLOT = 16;
  localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [7:0]  gen;
    logic        ec;
    logic [47:0] deadline;
    logic        dl_valid;
    logic        last;
  } timer_result_t;

  logic [47:0] expiry  [NSLOT];
  logic [31:0] period  [NSLOT];
  logic        busy    [NSLOT];
  logic [7:0]  tag     [NSLOT];

  timer_result_t due_results[$];

  function automatic logic find_earliest(output logic [47:0] t);
    logic any;
    any = 1'b0;
    t = '0;
    for (int i = 0; i < NSLOT; i++)
      if (busy[i] && (!any || expiry[i] < t)) begin
        t = expiry[i];
        any = 1'b1;
      end
    return any;
  endfunction

  function automatic timer_result_t make_result(logic [2:0] k, logic [3:0] s, logic [7:0] g,
                                                logic ec, logic last);
    timer_result_t r;
    r.kind = k;
    r.slot = s;
    r.gen = g;
    r.ec = ec;
    r.last = last;
    r.dl_valid = last ? find_earliest(r.deadline) : 1'b0;
    if (!last) r.deadline = '0;
    return r;
  endfunction

  task automatic apply_timer_op(input logic [1:0] k, input logic [143:0] d);
    logic [47:0] when_t, now_t, cur;
    logic [31:0] ivl;
    logic [3:0]  tslot;
    logic [7:0]  tgen;
    logic [48:0] sum;
    logic        had, fired [NSLOT];
    int          free_s, pick;
    logic [2:0]  rk;
    when_t = d[47:0];
    ivl    = d[79:48];
    tslot  = d[83:80];
    tgen   = d[91:84];
    now_t  = d[139:92];
    case (k)
      tdq_pkg::K_ADD: begin
        free_s = -1;
        for (int i = NSLOT - 1; i >= 0; i--)
          if (!busy[i]) free_s = i;
        if (free_s < 0) begin
          due_results.push_back(make_result(tdq_pkg::RK_FULL, '0, '0, 1'b0, 1'b1));
        end else begin
          had = find_earliest(cur);
          busy[free_s] = 1'b1;
          expiry[free_s] = when_t;
          period[free_s] = ivl;
          tag[free_s] = tag[free_s] + 8'd1;
          due_results.push_back(make_result(tdq_pkg::RK_ADDED, free_s[3:0], tag[free_s],
                                            !had || when_t < cur, 1'b1));
        end
      end
      tdq_pkg::K_CANCEL: begin
        rk = tdq_pkg::RK_MISS;
        if (busy[tslot] && tag[tslot] == tgen) begin
          busy[tslot] = 1'b0;
          rk = tdq_pkg::RK_CANCELED;
        end
        due_results.push_back(make_result(rk, tslot, tgen, 1'b0, 1'b1));
      end
      tdq_pkg::K_TICK: begin
        for (int i = 0; i < NSLOT; i++) fired[i] = 1'b0;
        do begin
          pick = -1;
          for (int i = 0; i < NSLOT; i++)
            if (busy[i] && !fired[i] && expiry[i] <= now_t &&
                (pick < 0 || expiry[i] < expiry[pick]))
              pick = i;
          if (pick >= 0) begin
            fired[pick] = 1'b1;
            due_results.push_back(make_result(tdq_pkg::RK_EXPIRED, pick[3:0], tag[pick],
                                              1'b0, 1'b0));
          end
        end while (pick >= 0);
        for (int i = 0; i < NSLOT; i++)
          if (fired[i]) begin
            if (period[i] != 32'd0) begin
              sum = {1'b0, now_t} + {17'd0, period[i]};
              expiry[i] = sum[48] ? T_MAX : sum[47:0];
            end else begin
              busy[i] = 1'b0;
            end
          end
        due_results.push_back(make_result(tdq_pkg::RK_DONE, '0, '0, 1'b0, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    timer_result_t w;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        busy[i] = 1'b0;
        tag[i] = '0;
        expiry[i] = '0;
        period[i] = '0;
      end
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing expected: kind %0d", out_tuser);
          errors++;
        end else begin
          w = due_results.pop_front();
          check_field("result_kind", 64'(w.kind), 64'(out_tuser));
          check_field("slot", 64'(w.slot), 64'(out_tdata[3:0]));
          check_field("generation", 64'(w.gen), 64'(out_tdata[11:4]));
          check_field("earliest_changed", 64'(w.ec), 64'(out_tdata[12]));
          check_field("next_deadline", 64'(w.deadline), 64'(out_tdata[60:13]));
          check_field("next_valid", 64'(w.dl_valid), 64'(out_tdata[61]));
          check_field("last", 64'(w.last), 64'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) apply_timer_op(in_tuser, in_tdata);
    end
    outstanding = due_results.size();
  end

  initial begin
    errors = 0;
    outstanding = 0;
  end

endmodule

`default_nettype wire

// ----- test/tb_timer_deadline_queue_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_deadline_queue_unit
// drives add, cancel, tick and no-op words into the timer deadline queue with
// random gaps and output stalls; the checker beside it predicts and compares
// ----------------------------------------------------------------------------
`default_nettype none

module tb_timer_deadline_queue_unit;

  localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int N_RANDOM = 300;
  localparam int QUIET_FROM = 260;
  localparam int STALL_LIMIT = 6000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  int           errors, outstanding;
  int           words_sent = 0;
  logic         quiet = 1'b0;
  logic [7:0]   live_gen [16] = '{default: '0};

  always #4 clk = ~clk;

  timer_deadline_queue_unit u_dut (.*);

  tdq_checker u_chk (.*);

  task automatic send_word(logic [1:0] k, logic [47:0] when_t, logic [31:0] ivl,
                           logic [3:0] s, logic [7:0] g, logic [47:0] now_t);
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {4'($urandom), now_t, g, s, ivl, when_t};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  always @(posedge clk)
    if (out_tvalid && out_tready && out_tuser == tdq_pkg::RK_ADDED)
      live_gen[out_tdata[3:0]] <= out_tdata[11:4];

  initial begin
    logic held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (quiet) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if (!held && words_sent >= 150) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [47:0] tnow;
    int          sel;
    logic [3:0]  s;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, misses, ties, saturating re-arm, ignored kind, full
    send_word(tdq_pkg::K_TICK, '0, '0, '0, '0, '0);
    send_word(tdq_pkg::K_CANCEL, '0, '0, 4'd3, 8'd0, '0);
    send_word(tdq_pkg::K_ADD, 48'd1000, 32'd0, '0, '0, '0);
    send_word(tdq_pkg::K_ADD, 48'd500, 32'd100, '0, '0, '0);
    send_word(tdq_pkg::K_ADD, 48'd500, 32'd0, '0, '0, '0);
    send_word(tdq_pkg::K_ADD, T_MAX, 32'hFFFF_FFFF, '0, '0, '0);
    send_word(tdq_pkg::K_CANCEL, '0, '0, 4'd0, 8'd2, '0);
    send_word(tdq_pkg::K_CANCEL, '0, '0, 4'd0, 8'd1, '0);
    send_word(tdq_pkg::K_TICK, '0, '0, '0, '0, 48'd500);
    send_word(tdq_pkg::K_ADD, 48'd0, 32'd7, '0, '0, '0);
    send_word(tdq_pkg::K_NOP, rand48(), $urandom, 4'($urandom), 8'($urandom), rand48());
    send_word(tdq_pkg::K_TICK, '0, '0, '0, '0, T_MAX);
    send_word(tdq_pkg::K_CANCEL, '0, '0, 4'd15, 8'd255, '0);
    for (int i = 0; i < 13; i++)
      send_word(tdq_pkg::K_ADD, 48'd2000 + 48'(i), 32'd0, '0, '0, '0);
    send_word(tdq_pkg::K_ADD, 48'd5, 32'd0, '0, '0, '0);
    send_word(tdq_pkg::K_TICK, '0, '0, '0, '0, 48'd100000);

    tnow = 48'd1000;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == QUIET_FROM) quiet = 1'b1;
      sel = $urandom_range(0, 99);
      s = 4'($urandom);
      if (sel < 40) begin
        if ($urandom_range(0, 19) == 0)
          send_word(tdq_pkg::K_ADD, rand48(), $urandom, s, 8'($urandom), rand48());
        else
          send_word(tdq_pkg::K_ADD, tnow + 48'($urandom_range(0, 2000)),
                    $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(1, 1500)),
                    s, 8'($urandom), rand48());
      end else if (sel < 65) begin
        send_word(tdq_pkg::K_CANCEL, rand48(), $urandom, s,
                  $urandom_range(0, 4) != 0 ? live_gen[s] : 8'($urandom), rand48());
      end else if (sel < 95) begin
        tnow = tnow + 48'($urandom_range(0, 800));
        send_word(tdq_pkg::K_TICK, rand48(), $urandom, s, 8'($urandom),
                  $urandom_range(0, 19) == 0 ? rand48() : tnow);
      end else begin
        send_word(tdq_pkg::K_NOP, rand48(), $urandom, s, 8'($urandom), rand48());
      end
    end
    in_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && outstanding == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
